>>> rtl/core/asnp_pkg.sv
// package for the angular sector nearest point block
// holds beat types, request codes, fsm states and the cordic angle table
package asnp_pkg;

    localparam int NUM_SECTORS  = 360;
    localparam int SECTOR_BITS  = 9;
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_BITS    = 5;
    localparam int CORDIC_BITS  = 36;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_MIN_RANGE  = 2'd0,
        CFG_MAX_RANGE  = 2'd1,
        CFG_MIN_HEIGHT = 2'd2,
        CFG_MAX_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SQUARE,
        ST_ROTATE,
        ST_SCALE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_READ,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] point_x_mm;
        logic signed [15:0] point_y_mm;
        logic signed [15:0] point_z_mm;
        logic [8:0]         read_sector;
    } in_beat_t;

    typedef struct packed {
        logic               point_accepted;
        logic [8:0]         point_sector;
        logic               sector_valid;
        logic signed [15:0] near_x_mm;
        logic signed [15:0] near_y_mm;
        logic signed [15:0] near_z_mm;
        logic [31:0]        near_range_sq;
    } out_beat_t;

    typedef struct packed {
        logic capture;
        logic square;
        logic cordic_init;
        logic cordic_step;
        logic scale;
        logic mem_read_add;
        logic mem_read_rd;
        logic update;
        logic clear_start;
        logic clear_step;
        logic form_add;
        logic form_read;
        logic form_zero;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       cordic_last;
        logic       clear_last;
    } stat_t;

    function automatic logic [31:0] ang_tab(input logic [STEP_BITS-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667330;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/asnp_ctrl.sv
// controller state machine for the sector scan block
// depends on asnp_pkg for states, request codes and command structs
module asnp_ctrl import asnp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result register can take a new beat
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:      if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                unique case (stat.req_type)
                    REQ_ADD:   state_next = ST_ROTATE;
                    REQ_READ:  state_next = ST_READ;
                    REQ_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_ROTATE:    if (stat.cordic_last) state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_LOOKUP;
            ST_LOOKUP:    state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_DONE;
            ST_READ:      state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_DONE;
            ST_CLEAR:     if (stat.clear_last) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        in_ready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_INIT:      cmd.clear_step = 1'b1;
            ST_IDLE:      cmd.capture = in_valid;
            ST_SQUARE:
            begin
                cmd.square      = 1'b1;
                cmd.cordic_init = 1'b1;
                cmd.clear_start = 1'b1;
            end
            ST_ROTATE:    cmd.cordic_step = 1'b1;
            ST_SCALE:     cmd.scale = 1'b1;
            ST_LOOKUP:    cmd.mem_read_add = 1'b1;
            ST_UPDATE:    cmd.update = 1'b1;
            ST_READ:      cmd.mem_read_rd = 1'b1;
            ST_READ_WAIT: ;
            ST_CLEAR:     cmd.clear_step = 1'b1;
            ST_DONE:
            begin
                if (out_free)
                begin
                    unique case (stat.req_type)
                        REQ_ADD:  cmd.form_add = 1'b1;
                        REQ_READ: cmd.form_read = 1'b1;
                        default:  cmd.form_zero = 1'b1;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/asnp_dp.sv
// datapath: filters, iterative cordic, sector scaling and sector memory
// depends on asnp_pkg for beat types, command structs and the angle table
module asnp_dp import asnp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  in_beat_t    in_beat,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  logic [15:0] cfg_data,
    input  cmd_t        cmd,
    output stat_t       stat,
    output out_beat_t   out_beat
);

    // configuration registers
    logic [15:0] min_range_reg, max_range_reg;
    logic [14:0] min_height_reg, max_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg  <= 16'd100;
            max_range_reg  <= 16'd4000;
            min_height_reg <= 15'd400;
            max_height_reg <= 15'd2000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_RANGE:  min_range_reg  <= cfg_data;
                CFG_MAX_RANGE:  max_range_reg  <= cfg_data;
                CFG_MIN_HEIGHT: min_height_reg <= cfg_data[14:0];
                CFG_MAX_HEIGHT: max_height_reg <= cfg_data[14:0];
            endcase
        end
    end

    // captured request
    in_beat_t req_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_beat;
    end
    assign stat.req_type = req_reg.req_type;

    // squares and limits, registered
    logic [33:0] r2_reg;
    logic [31:0] lo_reg, hi_reg;
    logic        ok_reg;
    logic [31:0] xx, yy, zz, lo_sq, hi_sq;
    logic [33:0] r2_sum;
    logic [15:0] az;
    logic        z_ok;
    always_comb
    begin
        xx     = unsigned'(32'(req_reg.point_x_mm) * 32'(req_reg.point_x_mm));
        yy     = unsigned'(32'(req_reg.point_y_mm) * 32'(req_reg.point_y_mm));
        zz     = unsigned'(32'(req_reg.point_z_mm) * 32'(req_reg.point_z_mm));
        r2_sum = {2'b0, xx} + {2'b0, yy} + {2'b0, zz};
        lo_sq  = min_range_reg * min_range_reg;
        hi_sq  = max_range_reg * max_range_reg;
        az     = req_reg.point_z_mm[15] ? 16'(-req_reg.point_z_mm)
                                        : req_reg.point_z_mm;
        z_ok   = !req_reg.point_z_mm[15]
                 && (req_reg.point_z_mm >= signed'({1'b0, min_height_reg}))
                 && (az <= {1'b0, max_height_reg});
    end
    always_ff @(posedge clk)
    begin
        if (cmd.square)
        begin
            r2_reg <= r2_sum;
            lo_reg <= lo_sq;
            hi_reg <= hi_sq;
            ok_reg <= z_ok;
        end
    end
    logic accept;
    assign accept = ok_reg && (r2_reg >= {2'b0, lo_reg}) && (r2_reg <= {2'b0, hi_reg});

    // iterative cordic vectoring, one step per cycle
    logic signed [CORDIC_BITS-1:0] re_reg, im_reg;
    logic [31:0]          acc_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic signed [CORDIC_BITS-1:0] re0, im0, re_sh, im_sh;
    always_comb
    begin
        re0   = CORDIC_BITS'(req_reg.point_y_mm) <<< 16;
        im0   = CORDIC_BITS'(req_reg.point_x_mm) <<< 16;
        re_sh = re_reg >>> step_reg;
        im_sh = im_reg >>> step_reg;
    end
    always_ff @(posedge clk)
    begin
        if (cmd.cordic_init)
        begin
            step_reg <= '0;
            if (req_reg.point_y_mm[15])
            begin
                re_reg  <= -re0;
                im_reg  <= -im0;
                acc_reg <= 32'h8000_0000;
            end
            else
            begin
                re_reg  <= re0;
                im_reg  <= im0;
                acc_reg <= 32'd0;
            end
        end
        else if (cmd.cordic_step)
        begin
            step_reg <= step_reg + 5'd1;
            if (im_reg > 0)
            begin
                re_reg  <= re_reg + im_sh;
                im_reg  <= im_reg - re_sh;
                acc_reg <= acc_reg + ang_tab(step_reg);
            end
            else
            begin
                re_reg  <= re_reg - im_sh;
                im_reg  <= im_reg + re_sh;
                acc_reg <= acc_reg - ang_tab(step_reg);
            end
        end
    end
    assign stat.cordic_last = (step_reg == 5'(CORDIC_STEPS - 1));

    // sector from angle, with the exact axis cases
    logic [SECTOR_BITS-1:0] sector_reg;
    logic [31:0] angle;
    logic [40:0] sprod;
    logic [SECTOR_BITS-1:0] sec_calc;
    always_comb
    begin
        angle = acc_reg + 32'h8000_0000;
        sprod = angle * 9'(NUM_SECTORS);
        if (sprod[40:32] >= 9'(NUM_SECTORS))
            sec_calc = 9'(NUM_SECTORS - 1);
        else
            sec_calc = sprod[40:32];
        if (req_reg.point_x_mm == 16'sd0)
            sec_calc = req_reg.point_y_mm[15] ? 9'(NUM_SECTORS - 1) : 9'(NUM_SECTORS / 2);
    end
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
            sector_reg <= sec_calc;
    end

    // sector memory with occupancy flags
    logic [47:0] point_mem [NUM_SECTORS];
    logic [31:0] range_mem [NUM_SECTORS];
    logic        occ_mem   [NUM_SECTORS];
    logic [47:0] pt_rd_reg;
    logic [31:0] rg_rd_reg;
    logic        occ_rd_reg;
    logic [SECTOR_BITS-1:0] rd_addr;
    logic        rd_in_range;
    logic [SECTOR_BITS-1:0] clr_reg;
    logic        upd_we;
    logic        occ_we, occ_wd;
    logic [SECTOR_BITS-1:0] occ_wa;

    assign rd_addr     = cmd.mem_read_add ? sector_reg : req_reg.read_sector;
    assign rd_in_range = rd_addr < 9'(NUM_SECTORS);

    // strictly nearer point replaces the stored one
    assign upd_we = cmd.update && accept && (!occ_rd_reg || r2_reg[31:0] < rg_rd_reg);

    // one flag write a cycle: set on accept, cleared by the sweep
    assign occ_we = (cmd.update && accept) || cmd.clear_step;
    assign occ_wa = cmd.clear_step ? clr_reg : sector_reg;
    assign occ_wd = !cmd.clear_step;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read_add || cmd.mem_read_rd)
        begin
            if (rd_in_range)
            begin
                pt_rd_reg  <= point_mem[rd_addr];
                rg_rd_reg  <= range_mem[rd_addr];
                occ_rd_reg <= occ_mem[rd_addr];
            end
            else
                occ_rd_reg <= 1'b0;
        end
        if (upd_we)
        begin
            point_mem[sector_reg] <= {req_reg.point_x_mm, req_reg.point_y_mm,
                                      req_reg.point_z_mm};
            range_mem[sector_reg] <= r2_reg[31:0];
        end
        if (occ_we)
            occ_mem[occ_wa] <= occ_wd;
    end

    // flag sweep address, one sector per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_start)
            clr_reg <= '0;
        else if (cmd.clear_step)
            clr_reg <= clr_reg + 9'd1;
    end
    assign stat.clear_last = (clr_reg == 9'(NUM_SECTORS - 1));

    // result beat register
    out_beat_t out_beat_reg, out_beat_next;
    always_comb
    begin
        out_beat_next = '0;
        if (cmd.form_add)
        begin
            out_beat_next.point_accepted = accept;
            out_beat_next.point_sector   = sector_reg;
        end
        if (cmd.form_read && occ_rd_reg)
        begin
            out_beat_next.sector_valid  = 1'b1;
            out_beat_next.near_x_mm     = pt_rd_reg[47:32];
            out_beat_next.near_y_mm     = pt_rd_reg[31:16];
            out_beat_next.near_z_mm     = pt_rd_reg[15:0];
            out_beat_next.near_range_sq = rg_rd_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.form_add || cmd.form_read || cmd.form_zero)
            out_beat_reg <= out_beat_next;
    end
    assign out_beat = out_beat_reg;

endmodule

>>> rtl/core/angular_sector_nearest_point.sv
// top level of the angular sector nearest point block
// depends on asnp_pkg, asnp_ctrl and asnp_dp
//
//  channel  | signals                                  | direction
//  in       | in_valid, in_ready, in_data              | request beats in
//  out      | out_valid, out_ready, out_data           | result beats out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register writes in
//
// an add runs 30 cordic steps, then scales, looks up and updates the sector; a read
// reads the memory; a clear sweeps one sector flag per cycle; the unused code forms a zero result
// one request in flight; the next can be taken in the cycle after the result is formed
// a stalled output holds the result; the next request runs up to its own result
// after reset a sweep empties all sectors with in_ready low
module angular_sector_nearest_point import asnp_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_beat_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_beat_t               out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    asnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    asnp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_beat  (out_data)
    );

endmodule

>>> rtl/core/asnp_checker.sv
// port checker for the angular sector nearest point block
// depends on asnp_pkg; bound to the top level below
module asnp_checker import asnp_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one request at a time
    a_in_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // a result never shows both add and read fields
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.sector_valid |-> !out_data.point_accepted)
        else $error("mixed result fields");

    // an accepted request gives no new result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result too early");

endmodule

bind angular_sector_nearest_point asnp_checker u_asnp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/tb.sv
// testbench for angular_sector_nearest_point: drives request beats and register writes
// predicts each result with its own cordic sector scoreboard; depends on asnp_pkg
module tb import asnp_pkg::*; ();

    // sector table predictor and queue of expected result beats
    class sector_scoreboard;
        logic [15:0] min_r, max_r;
        logic [14:0] min_h, max_h;
        bit          occ [NUM_SECTORS];
        logic signed [15:0] px [NUM_SECTORS];
        logic signed [15:0] py [NUM_SECTORS];
        logic signed [15:0] pz [NUM_SECTORS];
        logic [31:0] rsq [NUM_SECTORS];
        out_beat_t   pending [$];
        int          errors;

        function void reset_state();
            min_r = 16'd100;
            max_r = 16'd4000;
            min_h = 15'd400;
            max_h = 15'd2000;
            foreach (occ[i]) occ[i] = 0;
            pending.delete();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_MIN_RANGE:  min_r = v;
                CFG_MAX_RANGE:  max_r = v;
                CFG_MIN_HEIGHT: min_h = v[14:0];
                CFG_MAX_HEIGHT: max_h = v[14:0];
            endcase
        endfunction

        static function longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        function int angle_sector(longint x, longint y);
            logic [31:0] acc;
            longint re, im, nre, nim;
            logic [63:0] prod;
            acc = 0;
            if (x == 0) return (y < 0) ? NUM_SECTORS - 1 : NUM_SECTORS / 2;
            re = y * 65536;
            im = x * 65536;
            if (re < 0)
            begin
                re = -re;
                im = -im;
                acc = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (im > 0)
                begin
                    nre = re + fshr(im, i);
                    nim = im - fshr(re, i);
                    acc = acc + ang_table(i);
                end
                else
                begin
                    nre = re - fshr(im, i);
                    nim = im + fshr(re, i);
                    acc = acc - ang_table(i);
                end
                re = nre;
                im = nim;
            end
            acc = acc + 32'h8000_0000;
            prod = (64'(acc) * NUM_SECTORS) >> 32;
            if (prod >= NUM_SECTORS) prod = NUM_SECTORS - 1;
            return int'(prod);
        endfunction

        function logic [31:0] ang_table(int i);
            logic [31:0] t [30] = '{536870912, 316933406, 167458907, 85004756, 42667330,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
                20, 10, 5, 3, 1};
            return t[i];
        endfunction

        // note an accepted request beat
        function void note_request(in_beat_t b);
            out_beat_t e;
            longint x, y, z, r2, az;
            int s;
            bit ok;
            e = '0;
            case (req_t'(b.req_type))
                REQ_ADD:
                begin
                    x = b.point_x_mm;
                    y = b.point_y_mm;
                    z = b.point_z_mm;
                    s = angle_sector(x, y);
                    r2 = x * x + y * y + z * z;
                    az = z < 0 ? -z : z;
                    ok = r2 >= longint'(min_r) * min_r && r2 <= longint'(max_r) * max_r
                        && z >= longint'(min_h) && az <= longint'(max_h);
                    if (ok && (!occ[s] || r2[31:0] < rsq[s]))
                    begin
                        occ[s] = 1;
                        px[s] = b.point_x_mm;
                        py[s] = b.point_y_mm;
                        pz[s] = b.point_z_mm;
                        rsq[s] = r2[31:0];
                    end
                    e.point_accepted = ok;
                    e.point_sector = s[8:0];
                end
                REQ_READ:
                begin
                    if (b.read_sector < NUM_SECTORS && occ[b.read_sector])
                    begin
                        e.sector_valid = 1;
                        e.near_x_mm = px[b.read_sector];
                        e.near_y_mm = py[b.read_sector];
                        e.near_z_mm = pz[b.read_sector];
                        e.near_range_sq = rsq[b.read_sector];
                    end
                end
                REQ_CLEAR:
                    foreach (occ[i]) occ[i] = 0;
                default: ;
            endcase
            pending = {pending, e};
        endfunction

        // compare a result beat with the oldest expectation
        task check_result(out_beat_t got);
            out_beat_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result beat");
                return;
            end
            e = pending.pop_front();
            if (got.point_accepted !== e.point_accepted) report("point_accepted");
            if (got.point_sector !== e.point_sector) report("point_sector");
            if (got.sector_valid !== e.sector_valid) report("sector_valid");
            if (got.near_x_mm !== e.near_x_mm) report("near_x_mm");
            if (got.near_y_mm !== e.near_y_mm) report("near_y_mm");
            if (got.near_z_mm !== e.near_z_mm) report("near_z_mm");
            if (got.near_range_sq !== e.near_range_sq) report("near_range_sq");
        endtask

        task report(string what);
            errors++;
            $display("mismatch: %s at %0t", what, $realtime);
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    in_beat_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    out_beat_t   out_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    sector_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    localparam int QUIET_LIMIT = 20000;

    angular_sector_nearest_point uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // result sampling and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL angular_sector_nearest_point");
            $finish;
        end
    end

    // valid stays high after a beat until the next one or an idle cycle
    task automatic send_request(in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(b);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic set_filters(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        write_reg(CFG_MIN_RANGE, a);
        write_reg(CFG_MAX_RANGE, b);
        write_reg(CFG_MIN_HEIGHT, c);
        write_reg(CFG_MAX_HEIGHT, d);
        cfg_valid <= 0;
    endtask

    function automatic in_beat_t add_beat(int x, int y, int z);
        in_beat_t b;
        b = '0;
        b.req_type = REQ_ADD;
        b.point_x_mm = 16'(x);
        b.point_y_mm = 16'(y);
        b.point_z_mm = 16'(z);
        b.read_sector = 9'($urandom);
        return b;
    endfunction

    function automatic in_beat_t rd_beat(int s);
        in_beat_t b;
        b = in_beat_t'(59'({$urandom, $urandom}));
        b.req_type = REQ_READ;
        b.read_sector = 9'(s);
        return b;
    endfunction

    // one random request: mostly adds, most of them well-formed points near the filter window
    function automatic in_beat_t random_beat();
        in_beat_t b;
        int k;
        k = $urandom_range(99);
        b = in_beat_t'(59'({$urandom, $urandom}));
        if (k < 60)
        begin
            b.req_type = REQ_ADD;
            if ($urandom_range(3) != 0)
            begin
                b.point_x_mm = 16'(int'($urandom_range(6000)) - 3000);
                b.point_y_mm = 16'(int'($urandom_range(6000)) - 3000);
                b.point_z_mm = 16'($urandom_range(2400));
                if ($urandom_range(9) == 0) b.point_x_mm = '0;
            end
        end
        else if (k < 92)
        begin
            b.req_type = REQ_READ;
            if ($urandom_range(15) != 0) b.read_sector = 9'($urandom_range(NUM_SECTORS - 1));
        end
        else if (k < 95)
            b.req_type = REQ_CLEAR;
        else
            b.req_type = REQ_NONE;
        return b;
    endfunction

    initial
    begin
        sb = new();
        sb.reset_state();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes, exact axes, ties, reads, clear and unused code
        send_request(add_beat(0, 1000, 500));
        send_request(add_beat(0, -1000, 500));
        send_request(add_beat(0, 0, 500));
        send_request(add_beat(1000, 0, 500));
        send_request(add_beat(-1000, -1, 500));
        send_request(add_beat(32767, 32767, 32767));
        send_request(add_beat(-32768, -32768, -32768));
        send_request(add_beat(0, 1000, 500));
        send_request(add_beat(0, 900, 500));
        send_request(add_beat(0, 1000, 399));
        send_request(add_beat(0, 1000, 2001));
        send_request(rd_beat(NUM_SECTORS / 2));
        send_request(rd_beat(NUM_SECTORS - 1));
        send_request(rd_beat(0));
        send_request(rd_beat(NUM_SECTORS));
        send_request(rd_beat(511));
        send_request(in_beat_t'({REQ_CLEAR, 57'h1FF_FFFF_FFFF_FFFF}));
        send_request(rd_beat(NUM_SECTORS / 2));
        send_request(in_beat_t'({REQ_NONE, 57'h0}));
        drain();
        set_filters(16'd0, 16'hFFFF, 16'd0, 16'h7FFF);
        send_request(add_beat(0, 0, 0));
        send_request(add_beat(-32768, 32767, 0));
        send_request(rd_beat(NUM_SECTORS / 2));
        drain();

        // random phases over several filter settings and idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            case (ph)
                0: set_filters(16'd100, 16'd4000, 16'd400, 16'd2000);
                3: set_filters(16'd0, 16'hFFFF, 16'd0, 16'h7FFF);
                5: set_filters(16'hFFFF, 16'd0, 16'h7FFF, 16'd0);
                default: set_filters(16'($urandom_range(1500)),
                                     16'(1500 + $urandom_range(3000)),
                                     16'($urandom_range(600)),
                                     16'(600 + $urandom_range(1500)));
            endcase
            for (int n = 0; n < 250; n++) send_request(random_beat());
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS angular_sector_nearest_point");
        else
            $display("FAIL angular_sector_nearest_point");
        $finish;
    end
endmodule
